// ----- rtl/fcce_pkg.sv -----
// Package for the cluster chain engine: entry widths, link marks,
// action, status and sequencer state codes.
// No dependencies.
package fcce_pkg;

   localparam int LINK_W = 28;
   localparam int CNT_W  = 12;

   localparam logic [LINK_W-1:0] LINK_MASK  = 28'hFFFFFFF;
   localparam logic [LINK_W-1:0] CHAIN_END  = 28'hFFFFFF8;
   localparam logic [LINK_W-1:0] FIRST_DATA = 28'd2;

   typedef enum logic [1:0] {
      ACT_ALLOC = 2'd0,
      ACT_SET   = 2'd1,
      ACT_FREE  = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_NO_FREE = 2'd1,
      STAT_RANGE   = 2'd2,
      STAT_LIMIT   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SET,
      S_RDCHK,
      S_RDWAIT,
      S_SCAN,
      S_FREE_CHK,
      S_FREE_WR
   } state_type;

endpackage

// ----- rtl/fat_cluster_chain_engine_core.sv -----
// Cluster chain engine: allocation table store with allocate, set, free-chain
// and read requests run by a sequencer around one table memory.
// Depends on fcce_pkg.
//
// Usage: drive req_action, req_cluster, req_value and pulse start while busy
// is low; the word is taken at that edge. Exactly one result word follows,
// shown for one cycle with rsp_valid high; the receiver cannot stall it.
// csr_write_enable/csr_write_data write clusters_in_use; the user does so
// only while busy is low; the block itself does not enforce this. Set and
// out-of-range read answer from their state, read goes through check and
// wait, allocate scans entries from cluster 2 on (one memory read per cycle,
// pipelined against the zero compare), and free passes check and write per
// chain link, since each next link comes from the registered read of the
// one before. busy stays high until the result is issued; a new word can
// be taken in the cycle rsp_valid is shown. After reset the table memory is
// cleared one entry per cycle with busy high; csr writes are taken meanwhile.
module fat_cluster_chain_engine_core
   import fcce_pkg::*;
#(
   parameter int TABLE_ENTRIES = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_action,
   input  logic [LINK_W-1:0] req_cluster,
   input  logic [LINK_W-1:0] req_value,
   output logic              rsp_valid,
   output logic [CNT_W-1:0]  rsp_result_cluster,
   output logic [LINK_W-1:0] rsp_entry_value,
   output logic [CNT_W-1:0]  rsp_freed_count,
   output logic [1:0]        rsp_status,
   input  logic              csr_write_enable,
   input  logic [CNT_W-1:0]  csr_write_data
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int TW = (AW + 1 > CNT_W + 1) ? AW + 1 : CNT_W + 1;
   localparam logic [TW-1:0] TE_TOP  = TW'(TABLE_ENTRIES);
   localparam logic [AW-1:0] LAST_IX = AW'(TABLE_ENTRIES - 1);

   logic [LINK_W-1:0] table_mem [TABLE_ENTRIES];
   logic [LINK_W-1:0] rd_data_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [LINK_W-1:0] mem_wdata;
   logic [AW-1:0]     mem_raddr;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cu_ff;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic [LINK_W-1:0] cl_ff, cl_in;
   logic [LINK_W-1:0] val_ff, val_in;
   logic [TW-1:0]     scan_addr_ff, scan_addr_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [TW-1:0]     chk_addr_ff, chk_addr_in;
   logic [CNT_W-1:0]  freed_ff, freed_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]  rsp_cluster_ff, rsp_cluster_in;
   logic [LINK_W-1:0] rsp_entry_ff, rsp_entry_in;
   logic [CNT_W-1:0]  rsp_freed_ff, rsp_freed_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   logic [CNT_W:0]    cu_plus;
   logic [TW-1:0]     top;
   logic [LINK_W-1:0] top_wide;
   logic              cl_in_range;

   always_comb begin
      cu_plus = {1'b0, cu_ff} + (CNT_W + 1)'(2);
      if (TW'(cu_plus) < TE_TOP) begin
         top = TW'(cu_plus);
      end else begin
         top = TE_TOP;
      end
      top_wide    = LINK_W'(top);
      cl_in_range = (cl_ff >= FIRST_DATA) && (cl_ff < top_wide);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= table_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cu_ff        <= CNT_W'(4094);
         clr_addr_ff  <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            cu_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cl_ff          <= cl_in;
      val_ff         <= val_in;
      scan_addr_ff   <= scan_addr_in;
      chk_addr_ff    <= chk_addr_in;
      freed_ff       <= freed_in;
      rsp_cluster_ff <= rsp_cluster_in;
      rsp_entry_ff   <= rsp_entry_in;
      rsp_freed_ff   <= rsp_freed_in;
      rsp_status_ff  <= rsp_status_in;
   end

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      cl_in          = cl_ff;
      val_in         = val_ff;
      scan_addr_in   = scan_addr_ff;
      chk_vld_in     = 1'b0;
      chk_addr_in    = chk_addr_ff;
      freed_in       = freed_ff;
      mem_we         = 1'b0;
      mem_waddr      = cl_ff[AW-1:0];
      mem_wdata      = '0;
      mem_raddr      = cl_ff[AW-1:0];
      rsp_valid_in   = 1'b0;
      rsp_cluster_in = '0;
      rsp_entry_in   = '0;
      rsp_freed_in   = '0;
      rsp_status_in  = STAT_OK;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == LAST_IX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cl_in        = req_cluster;
               val_in       = req_value;
               scan_addr_in = TW'(FIRST_DATA);
               freed_in     = '0;
               unique case (action_type'(req_action))
                  ACT_ALLOC: state_in = S_SCAN;
                  ACT_SET:   state_in = S_SET;
                  ACT_FREE:  state_in = S_FREE_CHK;
                  ACT_READ:  state_in = S_RDCHK;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_SET: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (cl_in_range) begin
               mem_we    = 1'b1;
               mem_wdata = val_ff;
            end else begin
               rsp_status_in = STAT_RANGE;
            end
         end
         S_RDCHK: begin
            if (cl_in_range) begin
               state_in = S_RDWAIT;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_RANGE;
               state_in      = S_IDLE;
            end
         end
         S_RDWAIT: begin
            rsp_valid_in = 1'b1;
            rsp_entry_in = rd_data_ff;
            state_in     = S_IDLE;
         end
         S_SCAN: begin
            if (chk_vld_ff && (rd_data_ff == '0)) begin
               mem_we         = 1'b1;
               mem_waddr      = chk_addr_ff[AW-1:0];
               mem_wdata      = LINK_MASK;
               rsp_valid_in   = 1'b1;
               rsp_cluster_in = CNT_W'(chk_addr_ff);
               state_in       = S_IDLE;
            end else if (scan_addr_ff < top) begin
               mem_raddr    = scan_addr_ff[AW-1:0];
               chk_vld_in   = 1'b1;
               chk_addr_in  = scan_addr_ff;
               scan_addr_in = scan_addr_ff + TW'(1);
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_NO_FREE;
               state_in      = S_IDLE;
            end
         end
         S_FREE_CHK: begin
            rsp_freed_in = freed_ff;
            if (!((cl_ff >= FIRST_DATA) && (cl_ff < CHAIN_END))) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (!cl_in_range) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_RANGE;
               state_in      = S_IDLE;
            end else if (freed_ff >= cu_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_LIMIT;
               state_in      = S_IDLE;
            end else begin
               state_in = S_FREE_WR;
            end
         end
         S_FREE_WR: begin
            mem_we   = 1'b1;
            cl_in    = rd_data_ff;
            freed_in = freed_ff + CNT_W'(1);
            state_in = S_FREE_CHK;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_cluster = rsp_cluster_ff;
   assign rsp_entry_value    = rsp_entry_ff;
   assign rsp_freed_count    = rsp_freed_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

// ----- dv/fat_cluster_chain_engine_core_tb.sv -----
`timescale 1ns / 1ps
// Testbench for fat_cluster_chain_engine_core: a directed table, then random phases
// of allocate, set, free-chain and read words, each result checked against a fixed
// answer or a shadow table. Depends on fcce_pkg and the core RTL.
module fat_cluster_chain_engine_core_tb;
   import fcce_pkg::*;

   localparam int TABLE_ENTRIES = 4096;
   localparam int AW            = $clog2(TABLE_ENTRIES);
   localparam int RANDOM_WORDS  = 1550;

   typedef struct packed {
      logic [CNT_W-1:0]  result_cluster;
      logic [LINK_W-1:0] entry_value;
      logic [CNT_W-1:0]  freed_count;
      status_type        status;
   } fat_answer_type;

   typedef struct packed {
      logic              is_csr;
      logic [CNT_W-1:0]  csr_data;
      action_type        action;
      logic [LINK_W-1:0] cluster;
      logic [LINK_W-1:0] value;
      logic              has_answer;
      fat_answer_type    answer;
   } plan_row_type;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              start            = 1'b0;
   logic              busy;
   logic [1:0]        req_action       = ACT_ALLOC;
   logic [LINK_W-1:0] req_cluster      = '0;
   logic [LINK_W-1:0] req_value        = '0;
   logic              rsp_valid;
   logic [CNT_W-1:0]  rsp_result_cluster;
   logic [LINK_W-1:0] rsp_entry_value;
   logic [CNT_W-1:0]  rsp_freed_count;
   logic [1:0]        rsp_status;
   logic              csr_write_enable = 1'b0;
   logic [CNT_W-1:0]  csr_write_data   = '0;

   logic [31:0]       shadow_fat [TABLE_ENTRIES];
   logic [CNT_W-1:0]  shadow_limit = 12'd4094;
   fat_answer_type    expected_answers [$];
   logic              row_typed = 1'b0;
   fat_answer_type    row_expect;
   int                mismatches = 0;

   fat_cluster_chain_engine_core #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_cluster       (req_cluster),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_result_cluster(rsp_result_cluster),
      .rsp_entry_value   (rsp_entry_value),
      .rsp_freed_count   (rsp_freed_count),
      .rsp_status        (rsp_status),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic fat_answer_type predict_fat_op(input action_type act,
                                                     input logic [LINK_W-1:0] cl,
                                                     input logic [LINK_W-1:0] val);
      fat_answer_type ans;
      int unsigned    top;
      int unsigned    c;
      int unsigned    nxt;
      int unsigned    freed;
      logic           found;
      logic           done;
      ans.result_cluster = '0;
      ans.entry_value    = '0;
      ans.freed_count    = '0;
      ans.status         = STAT_OK;
      top = shadow_limit + 2;
      if (top > TABLE_ENTRIES) top = TABLE_ENTRIES;
      case (act)
         ACT_ALLOC: begin
            ans.status = STAT_NO_FREE;
            found = 1'b0;
            for (c = 2; c < top && !found; c++) begin
               if (shadow_fat[c[AW-1:0]][LINK_W-1:0] == '0) begin
                  shadow_fat[c[AW-1:0]][LINK_W-1:0] = LINK_MASK;
                  ans.result_cluster = c[CNT_W-1:0];
                  ans.status = STAT_OK;
                  found = 1'b1;
               end
            end
         end
         ACT_SET: begin
            if (cl >= 2 && cl < top) shadow_fat[cl[AW-1:0]][LINK_W-1:0] = val;
            else ans.status = STAT_RANGE;
         end
         ACT_FREE: begin
            c = 32'(cl);
            freed = 0;
            done = 1'b0;
            while (!done && c >= 2 && c < CHAIN_END) begin
               if (c >= top) begin
                  ans.status = STAT_RANGE;
                  done = 1'b1;
               end else if (freed >= shadow_limit) begin
                  ans.status = STAT_LIMIT;
                  done = 1'b1;
               end else begin
                  nxt = 32'(shadow_fat[c[AW-1:0]][LINK_W-1:0]);
                  shadow_fat[c[AW-1:0]][LINK_W-1:0] = '0;
                  freed++;
                  c = nxt;
               end
            end
            ans.freed_count = freed[CNT_W-1:0];
         end
         default: begin
            if (cl >= 2 && cl < top) ans.entry_value = shadow_fat[cl[AW-1:0]][LINK_W-1:0];
            else ans.status = STAT_RANGE;
         end
      endcase
      return ans;
   endfunction

   task automatic check_field(input string name, input logic [LINK_W-1:0] want,
                              input logic [LINK_W-1:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : scoreboard
      fat_answer_type want;
      fat_answer_type calc;
      if (reset) begin
         foreach (shadow_fat[i]) shadow_fat[i] = '0;
         shadow_limit = 12'd4094;
         expected_answers.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_answers.size() == 0) begin
               mismatches++;
               $display("%0t: result word with none expected, expected nothing, actual %h %h %h %h",
                        $time, rsp_result_cluster, rsp_entry_value, rsp_freed_count, rsp_status);
            end else begin
               want = expected_answers.pop_front();
               check_field("result_cluster", LINK_W'(want.result_cluster),
                           LINK_W'(rsp_result_cluster));
               check_field("entry_value", want.entry_value, rsp_entry_value);
               check_field("freed_count", LINK_W'(want.freed_count), LINK_W'(rsp_freed_count));
               check_field("status", LINK_W'(want.status), LINK_W'(rsp_status));
            end
         end
         if (csr_write_enable) shadow_limit = csr_write_data;
         if (start && !busy) begin
            calc = predict_fat_op(action_type'(req_action), req_cluster, req_value);
            expected_answers.push_back(row_typed ? row_expect : calc);
         end
      end
   end

   function automatic plan_row_type word_row(input action_type act,
                                             input logic [LINK_W-1:0] cl,
                                             input logic [LINK_W-1:0] val);
      plan_row_type row;
      row = '0;
      row.action  = act;
      row.cluster = cl;
      row.value   = val;
      return row;
   endfunction

   function automatic plan_row_type checked_row(input action_type act,
                                                input logic [LINK_W-1:0] cl,
                                                input logic [LINK_W-1:0] val,
                                                input logic [CNT_W-1:0] rc,
                                                input logic [LINK_W-1:0] ev,
                                                input logic [CNT_W-1:0] fc,
                                                input status_type st);
      plan_row_type row;
      row = word_row(act, cl, val);
      row.has_answer            = 1'b1;
      row.answer.result_cluster = rc;
      row.answer.entry_value    = ev;
      row.answer.freed_count    = fc;
      row.answer.status         = st;
      return row;
   endfunction

   function automatic plan_row_type csr_row(input logic [CNT_W-1:0] data);
      plan_row_type row;
      row = '0;
      row.is_csr   = 1'b1;
      row.csr_data = data;
      return row;
   endfunction

   function automatic logic [LINK_W-1:0] pick_cluster(input int unsigned top);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 75 && top > 2) return LINK_W'($urandom_range(2, top - 1));
      if (r < 82) return LINK_W'(top - $urandom_range(0, 1));
      if (r < 88) return LINK_W'($urandom_range(0, 1));
      if (r < 94) return LINK_W'(CHAIN_END + $urandom_range(0, 7));
      return LINK_W'($urandom() & LINK_MASK);
   endfunction

   function automatic logic [LINK_W-1:0] pick_link(input int unsigned top);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55 && top > 2) return LINK_W'($urandom_range(2, top - 1));
      if (r < 70) return LINK_MASK;
      if (r < 78) return LINK_W'(CHAIN_END + $urandom_range(0, 6));
      if (r < 85) return '0;
      if (r < 92) return LINK_W'($urandom() & LINK_MASK);
      return pick_cluster(top);
   endfunction

   // enter at a falling edge; return at the falling edge after the word is taken
   task automatic send_word(input action_type act, input logic [LINK_W-1:0] cl,
                            input logic [LINK_W-1:0] val);
      start       = 1'b1;
      req_action  = act;
      req_cluster = cl;
      req_value   = val;
      while (busy) @(negedge clock);
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_answers.size() != 0) @(negedge clock);
   endtask

   task automatic write_limit(input logic [CNT_W-1:0] data);
      wait_drained();
      while (busy) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic pause_sender();
      int unsigned r;
      int unsigned n;
      r = $urandom_range(0, 99);
      if (r < 50) n = 0;
      else if (r < 85) n = $urandom_range(1, 3);
      else if (r < 97) n = $urandom_range(4, 12);
      else n = $urandom_range(20, 80);
      repeat (n) @(negedge clock);
   endtask

   initial begin : stimulus
      plan_row_type      plan [$];
      int unsigned       words_sent;
      int unsigned       r;
      int unsigned       top;
      int unsigned       phase_len;
      logic [CNT_W-1:0]  limit;
      logic              quiet;
      action_type        act;
      logic [LINK_W-1:0] cl;
      logic [LINK_W-1:0] val;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      plan.push_back(checked_row(ACT_READ, 28'd2, '0, '0, '0, '0, STAT_OK));
      plan.push_back(checked_row(ACT_READ, 28'd4095, '0, '0, '0, '0, STAT_OK));
      plan.push_back(checked_row(ACT_READ, 28'd4096, '0, '0, '0, '0, STAT_RANGE));
      plan.push_back(checked_row(ACT_READ, LINK_MASK, '0, '0, '0, '0, STAT_RANGE));
      plan.push_back(checked_row(ACT_SET, 28'd0, LINK_MASK, '0, '0, '0, STAT_RANGE));
      plan.push_back(checked_row(ACT_ALLOC, '0, '0, 12'd2, '0, '0, STAT_OK));
      plan.push_back(checked_row(ACT_SET, 28'd4095, LINK_MASK, '0, '0, '0, STAT_OK));
      plan.push_back(checked_row(ACT_READ, 28'd4095, '0, '0, LINK_MASK, '0, STAT_OK));
      plan.push_back(checked_row(ACT_SET, 28'd2, 28'd3, '0, '0, '0, STAT_OK));
      plan.push_back(checked_row(ACT_FREE, 28'd2, '0, '0, '0, 12'd2, STAT_OK));
      plan.push_back(checked_row(ACT_FREE, 28'd0, '0, '0, '0, '0, STAT_OK));
      plan.push_back(checked_row(ACT_FREE, CHAIN_END, '0, '0, '0, '0, STAT_OK));
      plan.push_back(checked_row(ACT_FREE, CHAIN_END - 1, '0, '0, '0, '0, STAT_RANGE));
      plan.push_back(word_row(ACT_SET, 28'd4, CHAIN_END - 1));
      plan.push_back(word_row(ACT_FREE, 28'd4, '0));
      plan.push_back(word_row(ACT_SET, 28'd5, 28'd5));
      plan.push_back(word_row(ACT_FREE, 28'd5, '0));
      plan.push_back(csr_row(12'd2));
      plan.push_back(word_row(ACT_SET, 28'd2, 28'd3));
      plan.push_back(word_row(ACT_SET, 28'd3, 28'd2));
      plan.push_back(word_row(ACT_FREE, 28'd2, '0));
      plan.push_back(csr_row(12'd1));
      plan.push_back(word_row(ACT_ALLOC, '0, '0));
      plan.push_back(checked_row(ACT_ALLOC, '0, '0, '0, '0, '0, STAT_NO_FREE));
      plan.push_back(csr_row(12'd0));
      plan.push_back(checked_row(ACT_ALLOC, '0, '0, '0, '0, '0, STAT_NO_FREE));
      plan.push_back(checked_row(ACT_SET, 28'd2, '0, '0, '0, '0, STAT_RANGE));
      plan.push_back(csr_row(12'd4095));
      plan.push_back(checked_row(ACT_READ, 28'd4095, '0, '0, LINK_MASK, '0, STAT_OK));
      plan.push_back(word_row(ACT_FREE, 28'd4095, '0));

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            write_limit(plan[i].csr_data);
         end else begin
            pause_sender();
            row_typed  = plan[i].has_answer;
            row_expect = plan[i].answer;
            send_word(plan[i].action, plan[i].cluster, plan[i].value);
         end
      end
      row_typed = 1'b0;

      words_sent = 0;
      while (words_sent < RANDOM_WORDS) begin
         r = $urandom_range(0, 99);
         if (r < 6) limit = 12'd0;
         else if (r < 12) limit = 12'd4094;
         else if (r < 16) limit = 12'd4095;
         else if (r < 76) limit = CNT_W'($urandom_range(1, 48));
         else limit = CNT_W'($urandom_range(0, 4095));
         write_limit(limit);
         top = limit + 2;
         if (top > TABLE_ENTRIES) top = TABLE_ENTRIES;
         phase_len = $urandom_range(20, 80);
         quiet = ($urandom_range(0, 3) == 0);
         repeat (phase_len) begin
            if (!quiet) pause_sender();
            if ($urandom_range(0, 49) == 0) wait_drained();
            r = $urandom_range(0, 99);
            cl  = pick_cluster(top);
            val = pick_link(top);
            if (r < 28) act = ACT_ALLOC;
            else if (r < 60) act = ACT_SET;
            else if (r < 80) act = ACT_FREE;
            else act = ACT_READ;
            if (act == ACT_ALLOC) begin
               cl  = LINK_W'($urandom() & LINK_MASK);
               val = LINK_W'($urandom() & LINK_MASK);
            end
            send_word(act, cl, val);
            words_sent++;
         end
      end

      wait_drained();
      repeat (20) @(negedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin : watchdog
      #400_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
